[hdl/imucaf_pkg.sv]
// shared types, opcodes, sequencer programme and trig tables for the attitude filter
package imucaf_pkg;

  // field widths
  localparam int GYRO_W  = 20;
  localparam int ACCEL_W = 16;
  localparam int ANGLE_W = 32;
  localparam int TS_W    = 16;
  localparam int IN_W    = 112;
  localparam int OUT_W   = 96;

  localparam logic [TS_W-1:0] TS_RESET = 16'd262;

  // multiplier operand and product widths
  localparam int MOP_W  = 34;
  localparam int PROD_W = 68;

  // filter coefficients, q16
  localparam int BLEND_OLD  = 65208;
  localparam int BLEND_NEW  = 328;
  localparam int SMOOTH_OLD = 58982;
  localparam int SMOOTH_NEW = 6554;

  // rotation constants for the sine table, q30
  localparam longint SIN1_Q30 = 64'sd18739379;
  localparam longint COS1_Q30 = 64'sd1073578288;

  // datapath opcodes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
  localparam logic [OP_W-1:0] OP_GYRO_X = 5'd1;
  localparam logic [OP_W-1:0] OP_GYRO_Y = 5'd2;
  localparam logic [OP_W-1:0] OP_GYRO_Z = 5'd3;
  localparam logic [OP_W-1:0] OP_SQ_X   = 5'd4;
  localparam logic [OP_W-1:0] OP_SQ_Y   = 5'd5;
  localparam logic [OP_W-1:0] OP_SQ_Z   = 5'd6;
  localparam logic [OP_W-1:0] OP_SETUP  = 5'd7;
  localparam logic [OP_W-1:0] OP_SRCH_P0 = 5'd8;
  localparam logic [OP_W-1:0] OP_SRCH_Q0 = 5'd9;
  localparam logic [OP_W-1:0] OP_SRCH_P1 = 5'd10;
  localparam logic [OP_W-1:0] OP_SRCH_Q1 = 5'd11;
  localparam logic [OP_W-1:0] OP_BLEND_P = 5'd12;
  localparam logic [OP_W-1:0] OP_BLEND_R = 5'd13;
  localparam logic [OP_W-1:0] OP_SMO_P  = 5'd14;
  localparam logic [OP_W-1:0] OP_SMO_R  = 5'd15;
  localparam logic [OP_W-1:0] OP_SMN_P  = 5'd16;
  localparam logic [OP_W-1:0] OP_SMN_R  = 5'd17;

  // sequencer programme
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = 6'd42;

  // controller to datapath commands
  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
    logic            out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef logic [32:0] sq_tab_t [0:90];

  // opcode issued at each step of the programme
  function automatic logic [OP_W-1:0] op_at(input logic [STEP_W-1:0] step);
    logic [OP_W-1:0] op;
    op = OP_NONE;
    if (step inside {[6'd8:6'd35]}) begin
      case (step[1:0])
        2'd0:    op = OP_SRCH_P0;
        2'd1:    op = OP_SRCH_Q0;
        2'd2:    op = OP_SRCH_P1;
        default: op = OP_SRCH_Q1;
      endcase
    end else begin
      case (step)
        6'd0:    op = OP_GYRO_X;
        6'd1:    op = OP_GYRO_Y;
        6'd2:    op = OP_GYRO_Z;
        6'd3:    op = OP_SQ_X;
        6'd4:    op = OP_SQ_Y;
        6'd5:    op = OP_SQ_Z;
        6'd6:    op = OP_SETUP;
        6'd36:   op = OP_BLEND_P;
        6'd37:   op = OP_BLEND_R;
        6'd38:   op = OP_SMO_P;
        6'd39:   op = OP_SMO_R;
        6'd40:   op = OP_SMN_P;
        6'd41:   op = OP_SMN_R;
        default: op = OP_NONE;
      endcase
    end
    return op;
  endfunction

  // squared q16 sine (or cosine) per whole degree, built by repeated rotation
  function automatic sq_tab_t build_sq_tab(input bit cos_order);
    longint c;
    longint s;
    longint nc;
    longint ns;
    longint v;
    longint sq16 [0:90];
    sq_tab_t t;
    int k;
    c = 64'sd1 <<< 30;
    s = 64'sd0;
    for (k = 0; k < 90; k++) begin
      sq16[k] = (s + 64'sd8192) >>> 14;
      nc = (c * COS1_Q30 - s * SIN1_Q30 + (64'sd1 <<< 29)) >>> 30;
      ns = (s * COS1_Q30 + c * SIN1_Q30 + (64'sd1 <<< 29)) >>> 30;
      c = nc;
      s = ns;
    end
    sq16[90] = (s + 64'sd8192) >>> 14;
    for (k = 0; k <= 90; k++) begin
      v = cos_order ? sq16[90-k] : sq16[k];
      t[k] = 33'(v * v);
    end
    return t;
  endfunction

  localparam sq_tab_t SIN_SQ = build_sq_tab(1'b0);
  localparam sq_tab_t COS_SQ = build_sq_tab(1'b1);

endpackage

[hdl/imucaf_ctrl.sv]
// sequencer that steps the datapath through one sample's programme
module imucaf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  imucaf_pkg::status_t   status,
  output logic                  idle,
  output imucaf_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [imucaf_pkg::STEP_W-1:0]  step_r, step_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.load     = 1'b0;
    cmd.op       = imucaf_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op   = imucaf_pkg::op_at(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == imucaf_pkg::STEP_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idle = (state_r == ST_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[hdl/imucaf_dpath.sv]
// datapath: shared multiplier, angle search lanes, accumulators and output register
module imucaf_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  imucaf_pkg::cmd_t              cmd,
  output imucaf_pkg::status_t           status,
  input  logic                          cfg_wr_en,
  input  logic [imucaf_pkg::TS_W-1:0]   cfg_wr_data,
  input  logic [imucaf_pkg::IN_W-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [imucaf_pkg::OUT_W-1:0]  out_tdata
);

  localparam int PW = imucaf_pkg::PROD_W;
  localparam int MW = imucaf_pkg::MOP_W;

  logic [imucaf_pkg::TS_W-1:0]       time_step_r;
  logic signed [19:0]                gx_r, gy_r, gz_r;
  logic signed [15:0]                ax_r, ay_r, az_r;
  logic [31:0]                       sqx_r, sqy_r, sqz_r;
  logic [31:0]                       p2_r [2];
  logic [31:0]                       q2_r [2];
  logic [6:0]                        lo_r [2];
  logic [6:0]                        hi_r [2];
  logic signed [PW-1:0]              hold_r [2];
  logic signed [PW-1:0]              prod_r;
  logic [imucaf_pkg::OP_W-1:0]       op_r;
  logic [31:0]                       gpitch_r, groll_r, gyaw_r;
  logic [31:0]                       spitch_r, sroll_r;
  logic                              seeded_r;
  logic                              out_valid_r;
  logic [imucaf_pkg::OUT_W-1:0]      out_data_r;

  logic [6:0]                        mid [2];
  logic signed [MW-1:0]              mop_a, mop_b;
  logic signed [8:0]                 pdeg, rdeg, rbase;
  logic signed [PW-1:0]              pa_new, ra_new;
  logic signed [PW-1:0]              rnd;
  logic signed [PW-1:0]              blend_p, blend_r, smooth_sum;

  // binary search midpoints
  assign mid[0] = 7'((8'(lo_r[0]) + 8'(hi_r[0])) >> 1);
  assign mid[1] = 7'((8'(lo_r[1]) + 8'(hi_r[1])) >> 1);

  // multiplier operand selection
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (cmd.op)
      imucaf_pkg::OP_GYRO_X: begin
        mop_a = MW'(gx_r);
        mop_b = $signed({18'd0, time_step_r});
      end
      imucaf_pkg::OP_GYRO_Y: begin
        mop_a = MW'(gy_r);
        mop_b = $signed({18'd0, time_step_r});
      end
      imucaf_pkg::OP_GYRO_Z: begin
        mop_a = MW'(gz_r);
        mop_b = $signed({18'd0, time_step_r});
      end
      imucaf_pkg::OP_SQ_X: begin
        mop_a = MW'(ax_r);
        mop_b = MW'(ax_r);
      end
      imucaf_pkg::OP_SQ_Y: begin
        mop_a = MW'(ay_r);
        mop_b = MW'(ay_r);
      end
      imucaf_pkg::OP_SQ_Z: begin
        mop_a = MW'(az_r);
        mop_b = MW'(az_r);
      end
      imucaf_pkg::OP_SRCH_P0: begin
        mop_a = $signed({2'd0, p2_r[0]});
        mop_b = $signed({1'b0, imucaf_pkg::COS_SQ[mid[0]]});
      end
      imucaf_pkg::OP_SRCH_Q0: begin
        mop_a = $signed({2'd0, q2_r[0]});
        mop_b = $signed({1'b0, imucaf_pkg::SIN_SQ[mid[0]]});
      end
      imucaf_pkg::OP_SRCH_P1: begin
        mop_a = $signed({2'd0, p2_r[1]});
        mop_b = $signed({1'b0, imucaf_pkg::COS_SQ[mid[1]]});
      end
      imucaf_pkg::OP_SRCH_Q1: begin
        mop_a = $signed({2'd0, q2_r[1]});
        mop_b = $signed({1'b0, imucaf_pkg::SIN_SQ[mid[1]]});
      end
      imucaf_pkg::OP_BLEND_P: begin
        mop_a = MW'($signed(gpitch_r));
        mop_b = MW'(imucaf_pkg::BLEND_OLD);
      end
      imucaf_pkg::OP_BLEND_R: begin
        mop_a = MW'($signed(groll_r));
        mop_b = MW'(imucaf_pkg::BLEND_OLD);
      end
      imucaf_pkg::OP_SMO_P: begin
        mop_a = MW'($signed(spitch_r));
        mop_b = MW'(imucaf_pkg::SMOOTH_OLD);
      end
      imucaf_pkg::OP_SMO_R: begin
        mop_a = MW'($signed(sroll_r));
        mop_b = MW'(imucaf_pkg::SMOOTH_OLD);
      end
      imucaf_pkg::OP_SMN_P: begin
        mop_a = MW'($signed(gpitch_r));
        mop_b = MW'(imucaf_pkg::SMOOTH_NEW);
      end
      imucaf_pkg::OP_SMN_R: begin
        mop_a = MW'($signed(groll_r));
        mop_b = MW'(imucaf_pkg::SMOOTH_NEW);
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  // whole-degree accelerometer angles from the search results
  always_comb begin
    if (ax_r == 16'sd0) begin
      pdeg = 9'sd0;
    end else if (!ax_r[15]) begin
      pdeg = -$signed({2'b0, lo_r[0]});
    end else begin
      pdeg = $signed({2'b0, lo_r[0]});
    end
    rbase = az_r[15] ? 9'sd90 + $signed({2'b0, lo_r[1]}) : $signed({2'b0, lo_r[1]});
    if (ay_r == 16'sd0) begin
      rdeg = az_r[15] ? 9'sd180 : 9'sd0;
    end else if (ay_r[15]) begin
      rdeg = -rbase;
    end else begin
      rdeg = rbase;
    end
  end

  // blend and smoothing sums
  assign rnd        = PW'(32768);
  assign pa_new     = PW'(pdeg) * PW'(256 * imucaf_pkg::BLEND_NEW);
  assign ra_new     = PW'(rdeg) * PW'(256 * imucaf_pkg::BLEND_NEW);
  assign blend_p    = prod_r + pa_new + rnd;
  assign blend_r    = prod_r + ra_new + rnd;
  assign smooth_sum = (op_r == imucaf_pkg::OP_SMN_P ? hold_r[0] : hold_r[1]) + prod_r + rnd;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= imucaf_pkg::TS_RESET;
    end else if (cfg_wr_en) begin
      time_step_r <= cfg_wr_data;
    end
  end

  // input capture and multiplier stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gx_r <= in_tdata[19:0];
      gy_r <= in_tdata[39:20];
      gz_r <= in_tdata[59:40];
      ax_r <= in_tdata[75:60];
      ay_r <= in_tdata[91:76];
      az_r <= in_tdata[107:92];
    end
    prod_r <= PW'(mop_a) * PW'(mop_b);
  end

  // apply the product of the previous cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= imucaf_pkg::OP_NONE;
      gpitch_r <= '0;
      groll_r  <= '0;
      gyaw_r   <= '0;
      spitch_r <= '0;
      sroll_r  <= '0;
      seeded_r <= 1'b0;
    end else begin
      op_r <= cmd.op;
      if (cmd.out_load) begin
        seeded_r <= 1'b1;
      end
      case (op_r)
        imucaf_pkg::OP_GYRO_X: groll_r  <= groll_r + prod_r[47:16];
        imucaf_pkg::OP_GYRO_Y: gpitch_r <= gpitch_r + prod_r[47:16];
        imucaf_pkg::OP_GYRO_Z: gyaw_r   <= gyaw_r + prod_r[47:16];
        imucaf_pkg::OP_SQ_X:   sqx_r    <= prod_r[31:0];
        imucaf_pkg::OP_SQ_Y:   sqy_r    <= prod_r[31:0];
        imucaf_pkg::OP_SQ_Z:   sqz_r    <= prod_r[31:0];
        imucaf_pkg::OP_SETUP: begin
          p2_r[0] <= sqx_r;
          q2_r[0] <= sqy_r + sqz_r;
          p2_r[1] <= az_r[15] ? sqz_r : sqy_r;
          q2_r[1] <= az_r[15] ? sqy_r : sqz_r;
          lo_r[0] <= 7'd0;
          hi_r[0] <= 7'd91;
          lo_r[1] <= 7'd0;
          hi_r[1] <= 7'd91;
        end
        imucaf_pkg::OP_SRCH_P0: hold_r[0] <= prod_r;
        imucaf_pkg::OP_SRCH_P1: hold_r[1] <= prod_r;
        imucaf_pkg::OP_SRCH_Q0: begin
          if (hold_r[0] >= prod_r) lo_r[0] <= mid[0];
          else hi_r[0] <= mid[0];
        end
        imucaf_pkg::OP_SRCH_Q1: begin
          if (hold_r[1] >= prod_r) lo_r[1] <= mid[1];
          else hi_r[1] <= mid[1];
        end
        imucaf_pkg::OP_BLEND_P: begin
          gpitch_r <= seeded_r ? blend_p[47:16] : 32'($signed(pdeg) * 32'sd256);
        end
        imucaf_pkg::OP_BLEND_R: begin
          groll_r <= seeded_r ? blend_r[47:16] : 32'($signed(rdeg) * 32'sd256);
        end
        imucaf_pkg::OP_SMO_P: hold_r[0] <= prod_r;
        imucaf_pkg::OP_SMO_R: hold_r[1] <= prod_r;
        imucaf_pkg::OP_SMN_P: spitch_r <= smooth_sum[47:16];
        imucaf_pkg::OP_SMN_R: sroll_r  <= smooth_sum[47:16];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {gyaw_r, sroll_r, spitch_r};
    end
  end

  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

endmodule

[hdl/imu_complementary_attitude_filter.sv]
// top level of the imu complementary pitch, roll and yaw filter
// One transaction on the input stream carries one IMU sample; one result transaction follows
// for each. A sample is taken when the block is idle, then runs through a fixed programme of
// steps and is loaded into the output register once that register is not held by a stalled
// consumer; only then is the block idle again and able to take a new sample. The programme is
// set by the single shared multiplier, which produces one product a cycle: gyro integration,
// the accelerometer squares, two seven-step binary searches for the whole-degree angles (two
// products a step) and the blend and smoothing products.
// The time step register may be written at any idle moment and takes effect on the next sample.
module imu_complementary_attitude_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [imucaf_pkg::TS_W-1:0]   cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, 4 bits zero fill
  input  logic [imucaf_pkg::IN_W-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pitch_angle, roll_angle, yaw_angle
  output logic [imucaf_pkg::OUT_W-1:0]  out_tdata
);

  imucaf_pkg::cmd_t    cmd;
  imucaf_pkg::status_t status;
  logic                idle;

  // input handshake
  assign in_tready = idle;

  // controller
  imucaf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_tready),
    .status  (status),
    .idle    (idle),
    .cmd     (cmd)
  );

  // datapath
  imucaf_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
